// ----- src/drt_pkg.sv -----
// Shared types, screen geometry and function codes for the dirty rectangle tracker.
// No dependencies; imported by every module of the block.
package drt_pkg;

   localparam int SCREEN_W = 320;
   localparam int SCREEN_H = 240;

   localparam int XW = $clog2(SCREEN_W + 1);
   localparam int YW = $clog2(SCREEN_H + 1);
   // signed working width: a 16-bit edge plus a 16-bit extent never wraps
   localparam int CW = 18;

   localparam logic [2:0] FUNC_MARK      = 3'd0;
   localparam logic [2:0] FUNC_MARK_ALL  = 3'd1;
   localparam logic [2:0] FUNC_QUERY     = 3'd2;
   localparam logic [2:0] FUNC_CLEAR     = 3'd3;
   localparam logic [2:0] FUNC_END_FRAME = 3'd4;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
      logic               full_update;
   } item_type;

   typedef struct packed {
      logic          keep;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      logic [XW-1:0] w;
      logic [YW-1:0] h;
   } mark_type;

   typedef struct packed {
      logic          overlap;
      logic          push_valid;
      logic [XW-1:0] push_x;
      logic [YW-1:0] push_y;
      logic [XW-1:0] push_w;
      logic [YW-1:0] push_h;
      logic          front_index;
      logic [31:0]   frames_done;
   } result_type;

endpackage

// ----- src/drt_clamp.sv -----
// Clamps a signed mark rectangle to the screen and flags it empty or not.
// Depends on drt_pkg.
module drt_clamp import drt_pkg::*; (
   input  item_type item_i,
   output mark_type mark_o
);

   localparam logic signed [CW-1:0] SW_S = CW'(SCREEN_W);
   localparam logic signed [CW-1:0] SH_S = CW'(SCREEN_H);

   logic signed [CW-1:0] x0, y0, w0, h0;
   logic signed [CW-1:0] x1, y1, w1, h1;
   logic signed [CW-1:0] w2, h2;

   always_comb begin
      x0 = {{(CW-16){item_i.x[15]}}, item_i.x};
      y0 = {{(CW-16){item_i.y[15]}}, item_i.y};
      w0 = {{(CW-16){item_i.w[15]}}, item_i.w};
      h0 = {{(CW-16){item_i.h[15]}}, item_i.h};

      // negative origin eats into the extent
      if (x0 < 0) begin
         x1 = '0;
         w1 = w0 + x0;
      end else begin
         x1 = x0;
         w1 = w0;
      end
      if (y0 < 0) begin
         y1 = '0;
         h1 = h0 + y0;
      end else begin
         y1 = y0;
         h1 = h0;
      end

      w2 = (x1 + w1 > SW_S) ? SW_S - x1 : w1;
      h2 = (y1 + h1 > SH_S) ? SH_S - y1 : h1;

      mark_o.keep = (w2 > 0) && (h2 > 0);
      mark_o.x    = x1[XW-1:0];
      mark_o.y    = y1[YW-1:0];
      mark_o.w    = w2[XW-1:0];
      mark_o.h    = h2[YW-1:0];
   end

endmodule

// ----- src/drt_state.sv -----
// Box, buffer and frame state with the per-item update and result logic.
// Depends on drt_pkg; takes the clamped mark from drt_clamp.
module drt_state import drt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  logic       tracking_enable,
   input  item_type   item_i,
   input  mark_type   mark_i,
   output result_type result_o
);

   logic [XW-1:0] box_left_ff, box_left_in;
   logic [YW-1:0] box_top_ff, box_top_in;
   logic [XW-1:0] box_width_ff, box_width_in;
   logic [YW-1:0] box_height_ff, box_height_in;
   logic          box_dirty_ff, box_dirty_in;
   logic          front_ff, front_in;
   logic [31:0]   frames_ff, frames_in;

   logic [XW:0]   box_right, mark_right, new_left, new_right;
   logic [YW:0]   box_bottom, mark_bottom, new_top, new_bottom;

   logic signed [CW-1:0] qx, qy, qw, qh;
   logic signed [CW-1:0] bl_s, bt_s, br_s, bb_s;
   logic                 hit;

   always_comb begin
      box_right   = {1'b0, box_left_ff} + {1'b0, box_width_ff};
      box_bottom  = {1'b0, box_top_ff} + {1'b0, box_height_ff};
      mark_right  = {1'b0, mark_i.x} + {1'b0, mark_i.w};
      mark_bottom = {1'b0, mark_i.y} + {1'b0, mark_i.h};
      new_left    = ({1'b0, mark_i.x} < {1'b0, box_left_ff}) ? {1'b0, mark_i.x}
                                                             : {1'b0, box_left_ff};
      new_top     = ({1'b0, mark_i.y} < {1'b0, box_top_ff}) ? {1'b0, mark_i.y}
                                                            : {1'b0, box_top_ff};
      new_right   = (mark_right > box_right) ? mark_right : box_right;
      new_bottom  = (mark_bottom > box_bottom) ? mark_bottom : box_bottom;

      qx   = {{(CW-16){item_i.x[15]}}, item_i.x};
      qy   = {{(CW-16){item_i.y[15]}}, item_i.y};
      qw   = {{(CW-16){item_i.w[15]}}, item_i.w};
      qh   = {{(CW-16){item_i.h[15]}}, item_i.h};
      bl_s = {{(CW-XW){1'b0}}, box_left_ff};
      bt_s = {{(CW-YW){1'b0}}, box_top_ff};
      br_s = {{(CW-XW-1){1'b0}}, box_right};
      bb_s = {{(CW-YW-1){1'b0}}, box_bottom};
      // touching edges count as a hit
      hit  = !((qx + qw < bl_s) || (qx > br_s) || (qy + qh < bt_s) || (qy > bb_s));
   end

   always_comb begin
      box_left_in   = box_left_ff;
      box_top_in    = box_top_ff;
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;
      box_dirty_in  = box_dirty_ff;
      front_in      = front_ff;
      frames_in     = frames_ff;
      result_o      = '0;

      unique case (item_i.func)
         FUNC_MARK: begin
            if (tracking_enable && mark_i.keep) begin
               if (!box_dirty_ff) begin
                  box_left_in   = mark_i.x;
                  box_top_in    = mark_i.y;
                  box_width_in  = mark_i.w;
                  box_height_in = mark_i.h;
                  box_dirty_in  = 1'b1;
               end else begin
                  box_left_in   = new_left[XW-1:0];
                  box_top_in    = new_top[YW-1:0];
                  box_width_in  = XW'(new_right - new_left);
                  box_height_in = YW'(new_bottom - new_top);
               end
            end
         end
         FUNC_MARK_ALL: begin
            box_left_in   = '0;
            box_top_in    = '0;
            box_width_in  = XW'(SCREEN_W);
            box_height_in = YW'(SCREEN_H);
            box_dirty_in  = 1'b1;
         end
         FUNC_QUERY: begin
            result_o.overlap = tracking_enable && box_dirty_ff && hit;
         end
         FUNC_CLEAR: begin
            box_dirty_in = 1'b0;
         end
         FUNC_END_FRAME: begin
            front_in  = ~front_ff;
            frames_in = frames_ff + 32'd1;
            if (item_i.full_update || !tracking_enable) begin
               result_o.push_valid = 1'b1;
               result_o.push_w     = XW'(SCREEN_W);
               result_o.push_h     = YW'(SCREEN_H);
            end else if (box_dirty_ff) begin
               result_o.push_valid = 1'b1;
               result_o.push_x     = box_left_ff;
               result_o.push_y     = box_top_ff;
               result_o.push_w     = box_width_ff;
               result_o.push_h     = box_height_ff;
               box_dirty_in        = 1'b0;
            end
         end
         default: begin
         end
      endcase

      result_o.front_index = front_in;
      result_o.frames_done = frames_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff   <= '0;
         box_top_ff    <= '0;
         box_width_ff  <= XW'(SCREEN_W);
         box_height_ff <= YW'(SCREEN_H);
         box_dirty_ff  <= 1'b1;
         front_ff      <= 1'b0;
         frames_ff     <= '0;
      end else if (go) begin
         box_left_ff   <= box_left_in;
         box_top_ff    <= box_top_in;
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
         box_dirty_ff  <= box_dirty_in;
         front_ff      <= front_in;
         frames_ff     <= frames_in;
      end
   end

endmodule

// ----- src/dirty_rectangle_tracker.sv -----
// Dirty rectangle tracker for a 320 x 240 double-buffered display: one item in, one
// result out per item, one item per cycle sustained while rsp_stall is low. An item
// is registered on transfer, worked through the clamp and box logic and lands in the
// result register once that register is free or draining; the single box register set
// is read and written once per cycle, which sets the rate. After reset the whole screen
// is dirty and tracking is on. The enable register is written over the csr_ channel,
// which is always ready; write it only while no items are in flight.
module dirty_rectangle_tracker import drt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_func,
   input  logic signed [15:0]   req_rect_x,
   input  logic signed [15:0]   req_rect_y,
   input  logic signed [15:0]   req_rect_w,
   input  logic signed [15:0]   req_rect_h,
   input  logic                 req_full_update,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_overlap,
   output logic                 rsp_push_valid,
   output logic [XW-1:0]        rsp_push_x,
   output logic [YW-1:0]        rsp_push_y,
   output logic [XW-1:0]        rsp_push_w,
   output logic [YW-1:0]        rsp_push_h,
   output logic                 rsp_front_index,
   output logic [31:0]          rsp_frames_done,

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;
   logic       enable_ff;

   logic       advance;
   item_type   req_item;
   mark_type   mark;
   result_type result;

   assign req_item = '{func: req_func, x: req_rect_x, y: req_rect_y,
                       w: req_rect_w, h: req_rect_h, full_update: req_full_update};

   // the working stage moves on whenever the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   drt_clamp u_clamp (
      .item_i (in_item_ff),
      .mark_o (mark)
   );

   drt_state u_state (
      .clock           (clock),
      .reset           (reset),
      .go              (advance),
      .tracking_enable (enable_ff),
      .item_i          (in_item_ff),
      .mark_i          (mark),
      .result_o        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         enable_ff    <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_overlap     = out_result_ff.overlap;
   assign rsp_push_valid  = out_result_ff.push_valid;
   assign rsp_push_x      = out_result_ff.push_x;
   assign rsp_push_y      = out_result_ff.push_y;
   assign rsp_push_w      = out_result_ff.push_w;
   assign rsp_push_h      = out_result_ff.push_h;
   assign rsp_front_index = out_result_ff.front_index;
   assign rsp_frames_done = out_result_ff.frames_done;

endmodule

// ----- src/drt_checker.sv -----
// Port-level checks for the dirty rectangle tracker, bound to the top level.
// Depends on drt_pkg and dirty_rectangle_tracker.
module drt_checker import drt_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_overlap,
   input logic                 rsp_push_valid,
   input logic [XW-1:0]        rsp_push_x,
   input logic [YW-1:0]        rsp_push_y,
   input logic [XW-1:0]        rsp_push_w,
   input logic [YW-1:0]        rsp_push_h,
   input logic                 rsp_front_index,
   input logic [31:0]          rsp_frames_done
);

   // a stalled result holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frames_done)
         && $stable(rsp_front_index) && $stable(rsp_push_valid))
      else $error("stalled result changed");

   // a pushed rectangle is never empty and stays on screen
   a_push_in_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_push_valid |-> rsp_push_w != '0 && rsp_push_h != '0
         && ({1'b0, rsp_push_x} + {1'b0, rsp_push_w}) <= (XW + 1)'(SCREEN_W)
         && ({1'b0, rsp_push_y} + {1'b0, rsp_push_h}) <= (YW + 1)'(SCREEN_H))
      else $error("pushed rectangle empty or off screen");

   // no push means the push fields are all zero
   a_no_push_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_push_valid |-> rsp_push_x == '0 && rsp_push_y == '0
         && rsp_push_w == '0 && rsp_push_h == '0)
      else $error("push fields set without a push");

   // a query result and a push never come from the same item
   a_overlap_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overlap |-> !rsp_push_valid)
      else $error("overlap and push together");

endmodule

bind dirty_rectangle_tracker drt_checker u_drt_checker (.*);
